/* src/gak_pkg.sv */
// ----------------------------------------------------------------------------
// gak_pkg
// Types, constants and small helpers for the GSM A5/1 / A5/2 keystream core.
// ----------------------------------------------------------------------------
`default_nettype none

package gak_pkg;

  // register file indexes
  localparam logic CFG_SESSION_KEY = 1'b0;
  localparam logic CFG_ALGORITHM   = 1'b1;

  // algorithm codes (the unused code behaves as the null cipher)
  localparam logic [1:0] ALG_NULL = 2'd0;
  localparam logic [1:0] ALG_A51  = 2'd1;
  localparam logic [1:0] ALG_A52  = 2'd2;

  // field widths
  localparam int KEY_W   = 64;
  localparam int COUNT_W = 22;
  localparam int CHUNK_W = 57;
  localparam int LOAD_W  = KEY_W + COUNT_W;

  // feedback taps
  localparam logic [18:0] R1_TAPS = 19'h72000;
  localparam logic [21:0] R2_TAPS = 22'h300000;
  localparam logic [22:0] R3_TAPS = 23'h700080;
  localparam logic [16:0] R4_TAPS = 17'h10800;

  // sequencer end counts
  localparam logic [6:0] LOAD_LAST  = 7'(LOAD_W - 1);
  localparam logic [6:0] MIX_LAST   = 7'd99;
  localparam logic [5:0] CHUNK_LAST = 6'(CHUNK_W - 1);
  localparam logic [1:0] LAST_CHUNK = 2'd3;

  // the four shift registers as one group
  typedef struct packed {
    logic [18:0] r1;
    logic [21:0] r2;
    logic [22:0] r3;
    logic [16:0] r4;
  } lfsr_set_t;

  function automatic logic maj3(input logic a, input logic b, input logic c);
    maj3 = (a & b) | (a & c) | (b & c);
  endfunction

  // A5/2 nonlinear output filter
  function automatic logic a52_filter(input lfsr_set_t s);
    a52_filter = s.r1[18] ^ s.r2[21] ^ s.r3[22]
               ^ maj3(s.r1[15], ~s.r1[14], s.r1[12])
               ^ maj3(~s.r2[16], s.r2[13], s.r2[9])
               ^ maj3(s.r3[18], s.r3[16], ~s.r3[13]);
  endfunction

endpackage

`default_nettype wire

/* src/gsm_a5_keystream_generator_core.sv */
// ----------------------------------------------------------------------------
// gsm_a5_keystream_generator_core
// GSM A5/1 and A5/2 keystream generator, one register clock per cycle unless stalled.
// ----------------------------------------------------------------------------
// Usage:
//   cfg port: write session_key (index 0) and algorithm (index 1) while idle.
//   input channel: one transfer carries a 22-bit COUNT; in_stall stays high
//   until all four chunks of that frame have been handed to the output.
//   output channel: four transfers per frame, chunk_index 0..3, 57 bits each,
//   earliest stream bit in bit 0; last marks chunk 3.
// Sequence:
//   A5/1: load of key and COUNT, then mix, then output of the four chunks.
//   A5/2: adds a prime step to fill the output delay stage before output.
//   Null cipher: zero output, no load or mix phase.
//   The single shared LFSR clock step serves load, mix and output: one step per cycle unless stalled.
// Stall:
//   a finished chunk sits in the output register; the next chunk keeps
//   building and the sequencer only pauses if it completes while the
//   previous one is still untaken.
// Reset:
//   synchronous, active low; returns to idle, drops out_valid, clears the
//   key and algorithm registers.
// ----------------------------------------------------------------------------
`default_nettype none

module gsm_a5_keystream_generator_core (
  input  wire logic        clk,
  input  wire logic        rst_n,
  // configuration
  input  wire logic        cfg_we,
  input  wire logic        cfg_index,
  input  wire logic [63:0] cfg_wdata,
  // input channel
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [21:0] in_frame_count,
  // output channel
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [1:0]       out_chunk_index,
  output logic [56:0]      out_keystream_bits,
  output logic             out_last
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOAD,
    ST_MIX,
    ST_PRIME,
    ST_RUN
  } state_t;

  // configuration registers
  logic [63:0] session_key_r;
  logic [1:0]  algorithm_r;

  // sequencer and datapath
  state_t                        state_r, state_nxt;
  logic [6:0]                    step_cnt_r, step_cnt_nxt;
  logic [5:0]                    bit_cnt_r, bit_cnt_nxt;
  logic [1:0]                    chunk_r, chunk_nxt;
  logic                          a52_r, a52_nxt;
  gak_pkg::lfsr_set_t            lfsr_r, lfsr_nxt;
  logic                          delayed_r, delayed_nxt;
  logic [gak_pkg::LOAD_W-1:0]    load_sr_r, load_sr_nxt;
  logic [gak_pkg::CHUNK_W-1:0]   acc_r, acc_nxt;

  // output register
  logic                          out_valid_r, out_valid_nxt;
  logic [1:0]                    out_chunk_r, out_chunk_nxt;
  logic [gak_pkg::CHUNK_W-1:0]   out_bits_r, out_bits_nxt;
  logic                          out_last_r, out_last_nxt;

  // shared clock step
  logic                          forced, load_bit;
  logic                          c0, c1, c2, m;
  gak_pkg::lfsr_set_t            clk_set;
  logic                          stream_bit;
  logic [gak_pkg::CHUNK_W-1:0]   chunk_full;
  logic                          out_free, in_xfer, run_step;
  logic [1:0]                    alg_wr;

  assign in_stall           = (state_r != ST_IDLE);
  assign in_xfer            = in_valid & ~in_stall;
  assign out_valid          = out_valid_r;
  assign out_chunk_index    = out_chunk_r;
  assign out_keystream_bits = out_bits_r;
  assign out_last           = out_last_r;
  assign out_free           = ~out_valid_r | ~out_stall;
  assign alg_wr             = cfg_wdata[1:0];

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      session_key_r <= '0;
      algorithm_r   <= gak_pkg::ALG_NULL;
    end else if (cfg_we) begin
      case (cfg_index)
        gak_pkg::CFG_SESSION_KEY: session_key_r <= cfg_wdata;
        gak_pkg::CFG_ALGORITHM:   algorithm_r   <= alg_wr;
        default:                  session_key_r <= session_key_r;
      endcase
    end
  end

  // one register clock: forced during load, else majority / R4 control
  always_comb begin
    forced   = (state_r == ST_LOAD);
    load_bit = forced & load_sr_r[0];
    if (a52_r) begin
      c0 = lfsr_r.r4[10];
      c1 = lfsr_r.r4[3];
      c2 = lfsr_r.r4[7];
    end else begin
      c0 = lfsr_r.r1[8];
      c1 = lfsr_r.r2[10];
      c2 = lfsr_r.r3[10];
    end
    m       = gak_pkg::maj3(c0, c1, c2);
    clk_set = lfsr_r;
    if (forced || m == c0)
      clk_set.r1 = {lfsr_r.r1[17:0], ^(lfsr_r.r1 & gak_pkg::R1_TAPS)};
    if (forced || m == c1)
      clk_set.r2 = {lfsr_r.r2[20:0], ^(lfsr_r.r2 & gak_pkg::R2_TAPS)};
    if (forced || m == c2)
      clk_set.r3 = {lfsr_r.r3[21:0], ^(lfsr_r.r3 & gak_pkg::R3_TAPS)};
    if (a52_r)
      clk_set.r4 = {lfsr_r.r4[15:0], ^(lfsr_r.r4 & gak_pkg::R4_TAPS)};
    // key / count bit goes into the feedback end
    clk_set.r1[0] = clk_set.r1[0] ^ load_bit;
    clk_set.r2[0] = clk_set.r2[0] ^ load_bit;
    clk_set.r3[0] = clk_set.r3[0] ^ load_bit;
    clk_set.r4[0] = clk_set.r4[0] ^ (load_bit & a52_r);
    // A5/2 forces four bits after the last load step
    if (forced && a52_r && step_cnt_r == gak_pkg::LOAD_LAST) begin
      clk_set.r1[15] = 1'b1;
      clk_set.r2[16] = 1'b1;
      clk_set.r3[18] = 1'b1;
      clk_set.r4[10] = 1'b1;
    end
    stream_bit = a52_r ? delayed_r
                       : (clk_set.r1[18] ^ clk_set.r2[21] ^ clk_set.r3[22]);
    chunk_full = {stream_bit, acc_r[gak_pkg::CHUNK_W-1:1]};
    run_step   = (bit_cnt_r != gak_pkg::CHUNK_LAST) | out_free;
  end

  // sequencer next state
  always_comb begin
    state_nxt     = state_r;
    step_cnt_nxt  = step_cnt_r;
    bit_cnt_nxt   = bit_cnt_r;
    chunk_nxt     = chunk_r;
    a52_nxt       = a52_r;
    lfsr_nxt      = lfsr_r;
    delayed_nxt   = delayed_r;
    load_sr_nxt   = load_sr_r;
    acc_nxt       = acc_r;
    out_valid_nxt = out_valid_r & out_stall;
    out_chunk_nxt = out_chunk_r;
    out_bits_nxt  = out_bits_r;
    out_last_nxt  = out_last_r;

    case (state_r)
      ST_IDLE: begin
        if (in_xfer) begin
          lfsr_nxt     = '0;
          delayed_nxt  = 1'b0;
          a52_nxt      = (algorithm_r == gak_pkg::ALG_A52);
          load_sr_nxt  = {in_frame_count, session_key_r};
          step_cnt_nxt = '0;
          bit_cnt_nxt  = '0;
          chunk_nxt    = '0;
          acc_nxt      = '0;
          if (algorithm_r == gak_pkg::ALG_A51 || algorithm_r == gak_pkg::ALG_A52)
            state_nxt = ST_LOAD;
          else
            state_nxt = ST_RUN;
        end
      end
      ST_LOAD: begin
        lfsr_nxt     = clk_set;
        load_sr_nxt  = {1'b0, load_sr_r[gak_pkg::LOAD_W-1:1]};
        step_cnt_nxt = step_cnt_r + 7'd1;
        if (step_cnt_r == gak_pkg::LOAD_LAST) begin
          step_cnt_nxt = '0;
          state_nxt    = ST_MIX;
        end
      end
      ST_MIX: begin
        lfsr_nxt     = clk_set;
        step_cnt_nxt = step_cnt_r + 7'd1;
        if (step_cnt_r == gak_pkg::MIX_LAST) begin
          step_cnt_nxt = '0;
          state_nxt    = a52_r ? ST_PRIME : ST_RUN;
        end
      end
      ST_PRIME: begin
        // fill the A5/2 output delay from the mixed registers
        delayed_nxt = gak_pkg::a52_filter(lfsr_r);
        state_nxt   = ST_RUN;
      end
      ST_RUN: begin
        if (run_step) begin
          lfsr_nxt    = clk_set;
          delayed_nxt = gak_pkg::a52_filter(clk_set);
          acc_nxt     = chunk_full;
          bit_cnt_nxt = bit_cnt_r + 6'd1;
          if (bit_cnt_r == gak_pkg::CHUNK_LAST) begin
            // hand the finished chunk to the output register
            out_valid_nxt = 1'b1;
            out_chunk_nxt = chunk_r;
            out_bits_nxt  = chunk_full;
            out_last_nxt  = (chunk_r == gak_pkg::LAST_CHUNK);
            bit_cnt_nxt   = '0;
            chunk_nxt     = chunk_r + 2'd1;
            if (chunk_r == gak_pkg::LAST_CHUNK)
              state_nxt = ST_IDLE;
          end
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // state and registered outputs
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      step_cnt_r  <= '0;
      bit_cnt_r   <= '0;
      chunk_r     <= '0;
      a52_r       <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      step_cnt_r  <= step_cnt_nxt;
      bit_cnt_r   <= bit_cnt_nxt;
      chunk_r     <= chunk_nxt;
      a52_r       <= a52_nxt;
    end
    lfsr_r      <= lfsr_nxt;
    delayed_r   <= delayed_nxt;
    load_sr_r   <= load_sr_nxt;
    acc_r       <= acc_nxt;
    out_chunk_r <= out_chunk_nxt;
    out_bits_r  <= out_bits_nxt;
    out_last_r  <= out_last_nxt;
  end

endmodule

`default_nettype wire

/* src/gak_checker.sv */
// ----------------------------------------------------------------------------
// gak_checker
// Port-level checks for the GSM A5 keystream core, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module gak_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_valid,
  input wire logic        in_stall,
  input wire logic        out_valid,
  input wire logic        out_stall,
  input wire logic [1:0]  out_chunk_index,
  input wire logic [56:0] out_keystream_bits,
  input wire logic        out_last
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_keystream_bits))
    else $error("stalled result changed");

  // last flag marks the fourth chunk
  a_last_idx: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_last == (out_chunk_index == 2'd3)))
    else $error("last flag does not match chunk index");

  // busy right after a frame transfer
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("ready again right after frame transfer");

  // while ready, only the final chunk of a frame can still be pending
  a_idle_out: assert property (@(posedge clk) disable iff (!rst_n)
    !in_stall && out_valid |-> out_last)
    else $error("idle with an unfinished frame pending");

endmodule

bind gsm_a5_keystream_generator_core gak_checker u_gak_checker (
  .clk                (clk),
  .rst_n              (rst_n),
  .in_valid           (in_valid),
  .in_stall           (in_stall),
  .out_valid          (out_valid),
  .out_stall          (out_stall),
  .out_chunk_index    (out_chunk_index),
  .out_keystream_bits (out_keystream_bits),
  .out_last           (out_last)
);

`default_nettype wire
